### hdl/lz_token_stream_decompressor_core_macros.svh
// Assertion helpers shared by the decompressor core.
`ifndef LZ_TOKEN_STREAM_DECOMPRESSOR_CORE_MACROS_SVH
`define LZ_TOKEN_STREAM_DECOMPRESSOR_CORE_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define LZD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never hold outside reset.
`define LZD_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

### hdl/lzd_pkg.sv
`timescale 1ns / 1ps

package lzd_pkg;

    localparam int WINDOW_SIZE_DEF = 4096;
    localparam int MAX_REF_LEN_DEF = 256;
    localparam int BPR_DEF         = 8;
    localparam int CMD_DEPTH_DEF   = 4;

    // Widths that cover the whole parameter range.
    localparam int DIST_W = 17;
    localparam int LEN_W  = 9;

    localparam logic [3:0] ST_RUN      = 4'd0;
    localparam logic [3:0] ST_DONE     = 4'd1;
    localparam logic [3:0] ST_MAGIC    = 4'd2;
    localparam logic [3:0] ST_TYPE     = 4'd3;
    localparam logic [3:0] ST_VARINT   = 4'd4;
    localparam logic [3:0] ST_ZERO_OFF = 4'd5;
    localparam logic [3:0] ST_OFF_PROD = 4'd6;
    localparam logic [3:0] ST_OFF_WIN  = 4'd7;
    localparam logic [3:0] ST_SIZE     = 4'd8;
    localparam logic [3:0] ST_AFTER    = 4'd9;
    localparam logic [3:0] ST_TRUNC    = 4'd10;
    localparam logic [3:0] ST_LEN      = 4'd11;

    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_O      = 8'h4F;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_FIXED  = 8'h33;
    localparam logic [7:0] CH_VARINT = 8'h35;
    localparam logic [7:0] VAR_MASK  = 8'h7F;
    localparam logic [7:0] VAR_CONT  = 8'h80;

    localparam logic [7:0] TOK_LIT = 8'h00;
    localparam logic [7:0] TOK_REF = 8'h01;

    typedef enum logic [1:0] {
        OP_EMPTY = 2'd0,
        OP_LIT   = 2'd1,
        OP_COPY  = 2'd2
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [7:0]         data;
        logic [DIST_W-1:0]  offset;
        logic [LEN_W-1:0]   len;
        logic [3:0]         status;
    } t_cmd;

    function automatic logic [7:0] magic_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = CH_M;
            2'd1:    c = CH_O;
            default: c = CH_C;
        endcase
        return c;
    endfunction

endpackage

### hdl/lz_token_stream_decompressor_core.sv
`timescale 1ns / 1ps
// LZ77 stream decompressor taking one compressed byte per request and returning
// decoded bytes packed up to BYTES_PER_RESULT per result, each input byte giving one
// or more results with a common status and run_last on the final one. A parser
// takes one byte per cycle whenever its four-entry command queue has room; header,
// field and literal bytes each pass the executor as one command. In a back
// reference each copied byte is a history read (S_READ) followed by a history
// write (S_DATA) on the single-port window memory, so the executor handles one
// copied byte at a time; the input stalls once the queue fills. The history
// needs no clearing pass after reset, since only bytes written in the current
// stream are read back.
`include "lz_token_stream_decompressor_core_macros.svh"

module lz_token_stream_decompressor_core #(
    parameter int WINDOW_SIZE      = lzd_pkg::WINDOW_SIZE_DEF,
    parameter int MAX_REF_LEN      = lzd_pkg::MAX_REF_LEN_DEF,
    parameter int BYTES_PER_RESULT = lzd_pkg::BPR_DEF,
    parameter int CMD_DEPTH        = lzd_pkg::CMD_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_stream_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_out_data,
    output logic [3:0]  o_out_count,
    output logic [3:0]  o_status,
    output logic        o_run_last
);
    import lzd_pkg::*;

    t_cmd push_cmd, head_cmd;
    logic push, pop, full, head_valid;

    lzd_front #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .MAX_REF_LEN (MAX_REF_LEN)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_byte     (i_in_byte),
        .i_stream_last (i_stream_last),
        .o_in_ready    (o_in_ready),
        .i_full        (full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    lzd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (full),
        .o_valid (head_valid)
    );

    lzd_back #(
        .WINDOW_SIZE      (WINDOW_SIZE),
        .BYTES_PER_RESULT (BYTES_PER_RESULT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_out_count (o_out_count),
        .o_status    (o_status),
        .o_run_last  (o_run_last)
    );

    // A truncated stream still delivers the bytes decoded by its last request.
    `LZD_ASSERT_IMPL(a_count_bound, o_out_valid, o_out_count <= 4'(BYTES_PER_RESULT), "result count above lane width")
    `LZD_ASSERT_IMPL(a_full_beats, o_out_valid && !o_run_last, o_out_count == 4'(BYTES_PER_RESULT), "non-final beat is not full")
    `LZD_ASSERT_IMPL(a_error_empty, o_out_valid && o_status >= ST_MAGIC && o_status != ST_TRUNC, o_out_count == 4'd0, "error result carries data")
    `LZD_ASSERT_NEVER(a_status_range, o_out_valid && o_status > ST_LEN, "status code out of range")

endmodule

### hdl/lzd_front.sv
`timescale 1ns / 1ps

module lzd_front #(
    parameter int WINDOW_SIZE = lzd_pkg::WINDOW_SIZE_DEF,
    parameter int MAX_REF_LEN = lzd_pkg::MAX_REF_LEN_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [7:0]    i_in_byte,
    input  logic          i_stream_last,
    output logic          o_in_ready,
    input  logic          i_full,
    output logic          o_push,
    output lzd_pkg::t_cmd o_cmd
);
    import lzd_pkg::*;

    typedef enum logic [7:0] {
        PH_MAGIC   = 8'b0000_0001,
        PH_SIZE    = 8'b0000_0010,
        PH_TYPE    = 8'b0000_0100,
        PH_LITLEN  = 8'b0000_1000,
        PH_LITDATA = 8'b0001_0000,
        PH_REFOFF  = 8'b0010_0000,
        PH_REFLEN  = 8'b0100_0000,
        PH_DISCARD = 8'b1000_0000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_fmt, n_fmt;
    logic [2:0]  r_hidx, n_hidx;
    logic [31:0] r_decl, n_decl;
    logic [31:0] r_prod, n_prod;
    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_fidx, n_fidx;
    logic [31:0] r_dist, n_dist;
    logic [31:0] r_litrem, n_litrem;
    logic [3:0]  r_err, n_err;

    logic        accept;
    logic [6:0]  payload;
    logic        f_bad, f_done;
    logic [31:0] f_val, remain;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept;
    assign remain     = r_decl - r_prod;
    assign payload    = i_in_byte[6:0] & VAR_MASK[6:0];

    always_comb begin
        if (r_fmt) begin
            f_bad  = (r_fidx >= 3'd4) && ((payload > 7'd1) || ((i_in_byte & VAR_CONT) != 8'd0));
            f_done = ((i_in_byte & VAR_CONT) == 8'd0) && !f_bad;
            f_val  = r_acc | (32'(payload) << ({2'b00, r_fidx} * 5'd7));
        end else begin
            f_bad  = 1'b0;
            f_done = (r_fidx[1:0] == 2'd3);
            f_val  = r_acc | (32'(i_in_byte) << {r_fidx[1:0], 3'b000});
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_fmt    = r_fmt;
        n_hidx   = r_hidx;
        n_decl   = r_decl;
        n_prod   = r_prod;
        n_acc    = r_acc;
        n_fidx   = r_fidx;
        n_dist   = r_dist;
        n_litrem = r_litrem;
        n_err    = r_err;
        o_cmd.op     = OP_EMPTY;
        o_cmd.data   = i_in_byte;
        o_cmd.offset = '0;
        o_cmd.len    = '0;
        o_cmd.status = ST_RUN;

        unique case (r_phase)
            PH_MAGIC: begin
                if (r_hidx < 3'd3) begin
                    if (i_in_byte != magic_char(r_hidx[1:0])) begin
                        n_phase = PH_DISCARD;
                        n_err   = ST_MAGIC;
                    end else begin
                        n_hidx = r_hidx + 3'd1;
                    end
                end else if (i_in_byte == CH_FIXED || i_in_byte == CH_VARINT) begin
                    n_fmt   = (i_in_byte == CH_VARINT);
                    n_hidx  = 3'd0;
                    n_decl  = '0;
                    n_phase = PH_SIZE;
                end else begin
                    n_phase = PH_DISCARD;
                    n_err   = ST_MAGIC;
                end
            end
            PH_SIZE: begin
                n_decl = r_decl | (32'(i_in_byte) << {r_hidx[1:0], 3'b000});
                n_hidx = r_hidx + 3'd1;
                if (r_hidx == 3'd3) begin
                    n_hidx  = 3'd0;
                    n_prod  = '0;
                    n_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                if (r_prod == r_decl) begin
                    n_phase = PH_DISCARD;
                    n_err   = ST_AFTER;
                end else if (i_in_byte == TOK_LIT || i_in_byte == TOK_REF) begin
                    n_acc   = '0;
                    n_fidx  = 3'd0;
                    n_phase = (i_in_byte == TOK_LIT) ? PH_LITLEN : PH_REFOFF;
                end else begin
                    n_phase = PH_DISCARD;
                    n_err   = ST_TYPE;
                end
            end
            PH_LITLEN: begin
                n_acc  = f_val;
                n_fidx = r_fidx + 3'd1;
                if (f_bad) begin
                    n_phase = PH_DISCARD;
                    n_err   = ST_VARINT;
                end else if (f_done) begin
                    if (f_val > remain) begin
                        n_phase = PH_DISCARD;
                        n_err   = ST_SIZE;
                    end else begin
                        n_litrem = f_val;
                        n_phase  = (f_val != 32'd0) ? PH_LITDATA : PH_TYPE;
                    end
                end
            end
            PH_LITDATA: begin
                o_cmd.op = OP_LIT;
                n_prod   = r_prod + 32'd1;
                n_litrem = r_litrem - 32'd1;
                if (r_litrem == 32'd1) begin
                    n_phase = PH_TYPE;
                end
            end
            PH_REFOFF: begin
                n_acc  = f_val;
                n_fidx = r_fidx + 3'd1;
                if (f_bad) begin
                    n_phase = PH_DISCARD;
                    n_err   = ST_VARINT;
                end else if (f_done) begin
                    n_dist  = f_val;
                    n_acc   = '0;
                    n_fidx  = 3'd0;
                    n_phase = PH_REFLEN;
                end
            end
            PH_REFLEN: begin
                n_acc  = f_val;
                n_fidx = r_fidx + 3'd1;
                if (f_bad) begin
                    n_phase = PH_DISCARD;
                    n_err   = ST_VARINT;
                end else if (f_done) begin
                    n_phase = PH_DISCARD;
                    if (r_dist == 32'd0) begin
                        n_err = ST_ZERO_OFF;
                    end else if (r_dist > r_prod) begin
                        n_err = ST_OFF_PROD;
                    end else if (r_dist > 32'(WINDOW_SIZE)) begin
                        n_err = ST_OFF_WIN;
                    end else if (f_val > remain) begin
                        n_err = ST_SIZE;
                    end else if (f_val > 32'(MAX_REF_LEN)) begin
                        n_err = ST_LEN;
                    end else begin
                        o_cmd.op     = OP_COPY;
                        o_cmd.offset = r_dist[DIST_W-1:0];
                        o_cmd.len    = f_val[LEN_W-1:0];
                        n_prod       = r_prod + f_val;
                        n_phase      = PH_TYPE;
                    end
                end
            end
            default: begin
            end
        endcase

        if (n_phase == PH_DISCARD) begin
            o_cmd.status = n_err;
        end else if (i_stream_last) begin
            o_cmd.status = (n_phase == PH_TYPE && n_prod == n_decl) ? ST_DONE : ST_TRUNC;
        end

        // The last byte of a stream returns the parser to its reset state.
        if (i_stream_last) begin
            n_phase  = PH_MAGIC;
            n_fmt    = 1'b0;
            n_hidx   = 3'd0;
            n_decl   = '0;
            n_prod   = '0;
            n_acc    = '0;
            n_fidx   = 3'd0;
            n_dist   = '0;
            n_litrem = '0;
            n_err    = ST_RUN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC;
            r_fmt    <= 1'b0;
            r_hidx   <= 3'd0;
            r_decl   <= '0;
            r_prod   <= '0;
            r_acc    <= '0;
            r_fidx   <= 3'd0;
            r_dist   <= '0;
            r_litrem <= '0;
            r_err    <= ST_RUN;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_fmt    <= n_fmt;
            r_hidx   <= n_hidx;
            r_decl   <= n_decl;
            r_prod   <= n_prod;
            r_acc    <= n_acc;
            r_fidx   <= n_fidx;
            r_dist   <= n_dist;
            r_litrem <= n_litrem;
            r_err    <= n_err;
        end
    end

endmodule

### hdl/lzd_fifo.sv
`timescale 1ns / 1ps

// Command queue; DEPTH must be a power of two.
module lzd_fifo #(
    parameter int DEPTH = lzd_pkg::CMD_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lzd_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output lzd_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_valid
);
    import lzd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (AW+1)'(1);
            end
        end
    end

endmodule

### hdl/lzd_back.sv
`timescale 1ns / 1ps

module lzd_back #(
    parameter int WINDOW_SIZE      = lzd_pkg::WINDOW_SIZE_DEF,
    parameter int BYTES_PER_RESULT = lzd_pkg::BPR_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  lzd_pkg::t_cmd i_cmd,
    output logic          o_pop,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [63:0]   o_out_data,
    output logic [3:0]    o_out_count,
    output logic [3:0]    o_status,
    output logic          o_run_last
);
    import lzd_pkg::*;

    localparam int AW  = $clog2(WINDOW_SIZE);
    localparam int LNW = (BYTES_PER_RESULT > 1) ? $clog2(BYTES_PER_RESULT) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_DATA = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_wp, n_wp;
    logic [DIST_W-1:0]  r_dist, n_dist;
    logic [LEN_W-1:0]   r_rem, n_rem;
    logic [3:0]         r_st, n_st;
    logic [63:0]        r_lane_data, n_lane_data;
    logic [LNW-1:0]     r_lane_n, n_lane_n;
    logic [7:0]         r_rd_data;
    logic [7:0]         mem [WINDOW_SIZE];

    logic               out_free, emit, e_last, mem_we, lane_full, copy_fin, wrap;
    logic [63:0]        e_data, new_data;
    logic [3:0]         e_count, e_status;
    logic [7:0]         mem_wd;
    logic [AW-1:0]      wp_inc, rd_addr;
    logic [AW:0]        rd_full;

    assign out_free  = !o_out_valid || i_out_ready;
    assign wp_inc    = (r_wp == AW'(WINDOW_SIZE - 1)) ? '0 : r_wp + AW'(1);
    assign wrap      = {1'b0, r_wp} < r_dist[AW:0];
    assign rd_full   = wrap ? ({1'b0, r_wp} + (AW+1)'(WINDOW_SIZE) - r_dist[AW:0])
                            : ({1'b0, r_wp} - r_dist[AW:0]);
    assign rd_addr   = rd_full[AW-1:0];
    assign lane_full = (r_lane_n == LNW'(BYTES_PER_RESULT - 1));
    assign copy_fin  = (r_rem == LEN_W'(1));
    assign new_data  = r_lane_data | (64'(r_rd_data) << {r_lane_n, 3'b000});

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_dist      = r_dist;
        n_rem       = r_rem;
        n_st        = r_st;
        n_lane_data = r_lane_data;
        n_lane_n    = r_lane_n;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_wd      = i_cmd.data;
        emit        = 1'b0;
        e_data      = '0;
        e_count     = 4'd0;
        e_status    = i_cmd.status;
        e_last      = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_LIT: begin
                            mem_we  = 1'b1;
                            n_wp    = wp_inc;
                            emit    = 1'b1;
                            e_data  = 64'(i_cmd.data);
                            e_count = 4'd1;
                        end
                        OP_COPY: begin
                            if (i_cmd.len == '0) begin
                                emit = 1'b1;
                            end else begin
                                n_dist      = i_cmd.offset;
                                n_rem       = i_cmd.len;
                                n_st        = i_cmd.status;
                                n_lane_data = '0;
                                n_lane_n    = '0;
                                n_state     = S_READ;
                            end
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_DATA;
            end
            S_DATA: begin
                // A beat that fills the lane or ends the copy needs the output register.
                if (!(lane_full || copy_fin) || out_free) begin
                    mem_we = 1'b1;
                    mem_wd = r_rd_data;
                    n_wp   = wp_inc;
                    n_rem  = r_rem - LEN_W'(1);
                    if (lane_full || copy_fin) begin
                        emit        = 1'b1;
                        e_data      = new_data;
                        e_count     = 4'(r_lane_n) + 4'd1;
                        e_status    = r_st;
                        e_last      = copy_fin;
                        n_lane_data = '0;
                        n_lane_n    = '0;
                    end else begin
                        n_lane_data = new_data;
                        n_lane_n    = r_lane_n + LNW'(1);
                    end
                    n_state = copy_fin ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wp] <= mem_wd;
        end
        if (r_state == S_READ) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist      <= n_dist;
        r_rem       <= n_rem;
        r_st        <= n_st;
        r_lane_data <= n_lane_data;
        r_lane_n    <= n_lane_n;
        if (emit) begin
            o_out_data  <= e_data;
            o_out_count <= e_count;
            o_status    <= e_status;
            o_run_last  <= e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            if (emit) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import lzd_pkg::*;

    typedef logic [7:0] u8_t;

    typedef struct {
        logic [63:0] data;
        logic [3:0]  count;
        logic [3:0]  status;
        logic        last;
    } beat_t;

    localparam int HIST_DEPTH = 4096;

    localparam int PH_MAGIC   = 0;
    localparam int PH_SIZE    = 1;
    localparam int PH_TYPE    = 2;
    localparam int PH_LITLEN  = 3;
    localparam int PH_LITDATA = 4;
    localparam int PH_REFOFF  = 5;
    localparam int PH_REFLEN  = 6;
    localparam int PH_DISCARD = 7;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_in_byte;
    logic        i_stream_last;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_out_data;
    logic [3:0]  o_out_count;
    logic [3:0]  o_status;
    logic        o_run_last;

    lz_token_stream_decompressor_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .i_stream_last(i_stream_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data),
        .o_out_count  (o_out_count),
        .o_status     (o_status),
        .o_run_last   (o_run_last)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Decoder state as the predictor sees it.
    u8_t         hist [HIST_DEPTH];
    int          phase;
    bit          fmt_varint;
    int          hdr_idx;
    logic [31:0] size_decl;
    logic [31:0] produced;
    logic [31:0] field_acc;
    int          field_idx;
    logic [31:0] ref_dist;
    logic [31:0] lit_left;
    bit          err_flag;
    logic [3:0]  err_code;
    logic [63:0] lane_bytes;
    int          lane_cnt;

    beat_t decoded_q [$];
    beat_t beats_q [$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int bytes_sent;
    int streams_sent;
    int beats_checked;
    int mismatches;
    int status_seen [16];

    function automatic void clear_stream();
        phase      = PH_MAGIC;
        fmt_varint = 1'b0;
        hdr_idx    = 0;
        size_decl  = '0;
        produced   = '0;
        field_acc  = '0;
        field_idx  = 0;
        ref_dist   = '0;
        lit_left   = '0;
        err_flag   = 1'b0;
        err_code   = ST_RUN;
    endfunction

    function automatic void flush_beat();
        beat_t b;
        b.data   = lane_bytes;
        b.count  = 4'(lane_cnt);
        b.status = ST_RUN;
        b.last   = 1'b0;
        beats_q.push_back(b);
        lane_bytes = '0;
        lane_cnt   = 0;
    endfunction

    function automatic void emit_byte(input u8_t b);
        hist[produced % HIST_DEPTH] = b;
        produced++;
        lane_bytes |= 64'(b) << (8 * lane_cnt);
        lane_cnt++;
        if (lane_cnt >= 8) begin
            flush_beat();
        end
    endfunction

    function automatic void raise_error(input logic [3:0] code);
        err_flag = 1'b1;
        err_code = code;
        phase    = PH_DISCARD;
    endfunction

    function automatic void start_field(input int next_phase);
        field_acc = '0;
        field_idx = 0;
        phase     = next_phase;
    endfunction

    // Returns 0 while more bytes are needed, 1 when done, -1 on a malformed varint.
    function automatic int gather_field(input u8_t b);
        logic [31:0] payload;
        if (fmt_varint) begin
            payload = 32'(b & VAR_MASK);
            if (field_idx >= 4 && payload > 1) begin
                return -1;
            end
            field_acc |= payload << (7 * field_idx);
            if ((b & VAR_CONT) == 0) begin
                return 1;
            end
            field_idx++;
            return (field_idx >= 5) ? -1 : 0;
        end
        field_acc |= 32'(b) << (8 * field_idx);
        field_idx++;
        return (field_idx >= 4) ? 1 : 0;
    endfunction

    function automatic void expand_copy(input logic [31:0] len);
        if (ref_dist == 0) begin
            raise_error(ST_ZERO_OFF);
        end else if (ref_dist > produced) begin
            raise_error(ST_OFF_PROD);
        end else if (ref_dist > HIST_DEPTH) begin
            raise_error(ST_OFF_WIN);
        end else if (len > size_decl - produced) begin
            raise_error(ST_SIZE);
        end else if (len > MAX_REF_LEN_DEF) begin
            raise_error(ST_LEN);
        end else begin
            for (int unsigned i = 0; i < len; i++) begin
                emit_byte(hist[(produced - ref_dist) % HIST_DEPTH]);
            end
            phase = PH_TYPE;
        end
    endfunction

    function automatic void decode_byte(input u8_t b);
        int r;
        case (phase)
            PH_MAGIC: begin
                if (hdr_idx < 3) begin
                    if (b != magic_char(2'(hdr_idx))) begin
                        raise_error(ST_MAGIC);
                    end else begin
                        hdr_idx++;
                    end
                end else if (b == CH_FIXED || b == CH_VARINT) begin
                    fmt_varint = (b == CH_VARINT);
                    hdr_idx    = 0;
                    size_decl  = '0;
                    phase      = PH_SIZE;
                end else begin
                    raise_error(ST_MAGIC);
                end
            end
            PH_SIZE: begin
                size_decl |= 32'(b) << (8 * hdr_idx);
                hdr_idx++;
                if (hdr_idx >= 4) begin
                    hdr_idx  = 0;
                    produced = '0;
                    phase    = PH_TYPE;
                end
            end
            PH_TYPE: begin
                if (produced == size_decl) begin
                    raise_error(ST_AFTER);
                end else if (b == TOK_LIT) begin
                    start_field(PH_LITLEN);
                end else if (b == TOK_REF) begin
                    start_field(PH_REFOFF);
                end else begin
                    raise_error(ST_TYPE);
                end
            end
            PH_LITLEN: begin
                r = gather_field(b);
                if (r < 0) begin
                    raise_error(ST_VARINT);
                end else if (r > 0) begin
                    if (field_acc > size_decl - produced) begin
                        raise_error(ST_SIZE);
                    end else begin
                        lit_left = field_acc;
                        phase    = (lit_left != 0) ? PH_LITDATA : PH_TYPE;
                    end
                end
            end
            PH_LITDATA: begin
                emit_byte(b);
                lit_left--;
                if (lit_left == 0) begin
                    phase = PH_TYPE;
                end
            end
            PH_REFOFF: begin
                r = gather_field(b);
                if (r < 0) begin
                    raise_error(ST_VARINT);
                end else if (r > 0) begin
                    ref_dist = field_acc;
                    start_field(PH_REFLEN);
                end
            end
            PH_REFLEN: begin
                r = gather_field(b);
                if (r < 0) begin
                    raise_error(ST_VARINT);
                end else if (r > 0) begin
                    expand_copy(field_acc);
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void predict_request(input u8_t b, input bit last);
        logic [3:0] st;
        beats_q.delete();
        lane_bytes = '0;
        lane_cnt   = 0;
        if (!err_flag) begin
            decode_byte(b);
        end
        st = ST_RUN;
        if (err_flag) begin
            st = err_code;
        end else if (last) begin
            st = (phase == PH_TYPE && produced == size_decl) ? ST_DONE : ST_TRUNC;
        end
        if (lane_cnt > 0 || beats_q.size() == 0) begin
            flush_beat();
        end
        foreach (beats_q[k]) begin
            beats_q[k].status = st;
            beats_q[k].last   = (k == beats_q.size() - 1);
            decoded_q.push_back(beats_q[k]);
        end
        status_seen[st]++;
        if (last) begin
            clear_stream();
        end
    endfunction

    // Result checker and receiver-side ready generation.
    always @(posedge i_clk) begin
        beat_t e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                beats_checked++;
                if (decoded_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result data=%h count=%0d status=%0d last=%b",
                             $time, o_out_data, o_out_count, o_status, o_run_last);
                end else begin
                    e = decoded_q.pop_front();
                    if (o_out_data !== e.data || o_out_count !== e.count ||
                        o_status !== e.status || o_run_last !== e.last) begin
                        mismatches++;
                        $display("%0t: expected data=%h count=%0d status=%0d last=%b",
                                 $time, e.data, e.count, e.status, e.last);
                        $display("%0t: actual   data=%h count=%0d status=%0d last=%b",
                                 $time, o_out_data, o_out_count, o_status, o_run_last);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_request(input u8_t b, input bit last);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid    <= 1'b1;
        i_in_byte     <= b;
        i_stream_last <= last;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        predict_request(b, last);
        bytes_sent++;
    endtask

    task automatic send_stream(input u8_t s [$]);
        foreach (s[i]) begin
            send_request(s[i], i == s.size() - 1);
        end
        streams_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (decoded_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
    endtask

    function automatic void push_field(ref u8_t q [$], input bit v, input int unsigned x);
        if (v) begin
            while (x >= 'h80) begin
                q.push_back(u8_t'(x) | VAR_CONT);
                x = x >> 7;
            end
            q.push_back(u8_t'(x));
        end else begin
            for (int i = 0; i < 4; i++) begin
                q.push_back(u8_t'(x >> (8 * i)));
            end
        end
    endfunction

    function automatic void push_header(ref u8_t q [$], input bit v, input int unsigned sz);
        q.push_back(CH_M);
        q.push_back(CH_O);
        q.push_back(CH_C);
        q.push_back(v ? CH_VARINT : CH_FIXED);
        for (int i = 0; i < 4; i++) begin
            q.push_back(u8_t'(sz >> (8 * i)));
        end
    endfunction

    function automatic void push_literal(ref u8_t q [$], input bit v, input int n);
        q.push_back(TOK_LIT);
        push_field(q, v, n);
        repeat (n) q.push_back(u8_t'($urandom));
    endfunction

    function automatic void push_copy(ref u8_t q [$], input bit v, input int unsigned d,
                                      input int unsigned n);
        q.push_back(TOK_REF);
        push_field(q, v, d);
        push_field(q, v, n);
    endfunction

    // A well-formed stream with random tokens; the header is prepended once the size is known.
    function automatic void build_stream(ref u8_t s [$], input bit v, input int ntok);
        u8_t body [$];
        int unsigned prod;
        int unsigned d;
        int unsigned n;
        prod = 0;
        for (int t = 0; t < ntok; t++) begin
            if (prod == 0 || $urandom_range(1) == 0) begin
                n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
                push_literal(body, v, n);
            end else begin
                d = $urandom_range(1, (prod < HIST_DEPTH) ? prod : HIST_DEPTH);
                n = ($urandom_range(7) == 0) ? $urandom_range(0, MAX_REF_LEN_DEF)
                                             : $urandom_range(0, 24);
                push_copy(body, v, d, n);
            end
            prod += n;
        end
        s.delete();
        push_header(s, v, prod);
        s = {s, body};
    endfunction

    function automatic void corrupt_stream(ref u8_t s [$]);
        int pos;
        case ($urandom_range(9))
            6: begin
                pos    = $urandom_range(0, s.size() - 1);
                s[pos] = u8_t'($urandom);
            end
            7: begin
                pos = $urandom_range(1, s.size() - 1);
                s   = s[0:pos-1];
            end
            8: begin
                repeat ($urandom_range(1, 3)) s.push_back(u8_t'($urandom));
            end
            9: begin
                s[4] = s[4] + ($urandom_range(1) ? 8'd1 : 8'hFF);
            end
            default: begin
            end
        endcase
    endfunction

    task automatic test_headers();
        u8_t s [$];
        s = {CH_M, 8'h58};
        send_stream(s);
        s = {CH_M, CH_O, CH_C, 8'h34, 8'h00};
        send_stream(s);
        s.delete();
        push_header(s, 1'b0, 0);
        send_stream(s);
        s.delete();
        push_header(s, 1'b1, 0);
        s.push_back(TOK_LIT);
        s.push_back(8'h00);
        send_stream(s);
        s.delete();
        push_header(s, 1'b1, 1);
        s.push_back(8'hFF);
        s.push_back(8'h00);
        send_stream(s);
        s = {CH_M, CH_O};
        send_stream(s);
        drain_results();
    endtask

    task automatic test_tokens();
        u8_t s [$];
        // Tokens after the declared size is reached, even zero-length ones, are refused with ST_AFTER.
        s.delete();
        push_header(s, 1'b1, 2);
        push_literal(s, 1'b1, 2);
        push_literal(s, 1'b1, 0);
        push_copy(s, 1'b1, 1, 0);
        send_stream(s);
        // Overlapping copy in fixed format repeats the three-byte pattern.
        s.delete();
        push_header(s, 1'b0, 23);
        push_literal(s, 1'b0, 3);
        push_copy(s, 1'b0, 3, 20);
        send_stream(s);
        s.delete();
        push_header(s, 1'b1, 4);
        push_literal(s, 1'b1, 1);
        push_copy(s, 1'b1, 0, 1);
        send_stream(s);
        s.delete();
        push_header(s, 1'b1, 4);
        push_literal(s, 1'b1, 1);
        push_copy(s, 1'b1, 5, 1);
        send_stream(s);
        s.delete();
        push_header(s, 1'b1, 4);
        push_literal(s, 1'b1, 5);
        send_stream(s);
        s.delete();
        push_header(s, 1'b1, 4);
        push_literal(s, 1'b1, 1);
        push_copy(s, 1'b1, 1, 9);
        send_stream(s);
        // Reference fits the declared size but exceeds the length limit.
        s.delete();
        push_header(s, 1'b1, 400);
        push_literal(s, 1'b1, 1);
        push_copy(s, 1'b1, 1, 300);
        send_stream(s);
        // Five-byte varints: a payload of zero in the top byte is fine; two, or a set continuation bit, is not.
        s.delete();
        push_header(s, 1'b1, 1);
        s = {s, TOK_LIT, 8'h81, 8'h80, 8'h80, 8'h80, 8'h00, 8'hAA};
        send_stream(s);
        s.delete();
        push_header(s, 1'b1, 1);
        s = {s, TOK_LIT, 8'h80, 8'h80, 8'h80, 8'h80, 8'h02, 8'h11, 8'h22};
        send_stream(s);
        s.delete();
        push_header(s, 1'b1, 1);
        s = {s, TOK_REF, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80};
        send_stream(s);
        s.delete();
        push_header(s, 1'b1, 9);
        push_literal(s, 1'b1, 9);
        s = s[0:s.size()-4];
        send_stream(s);
        drain_results();
    endtask

    // Fills more than the whole window, copies from its far edge, then one byte past it.
    task automatic test_window();
        u8_t s [$];
        s.delete();
        push_header(s, 1'b1, 16 + 17 * 256 + 8 + 1);
        push_literal(s, 1'b1, 16);
        repeat (17) push_copy(s, 1'b1, 16, 256);
        push_copy(s, 1'b1, HIST_DEPTH, 8);
        push_copy(s, 1'b1, HIST_DEPTH + 1, 1);
        send_stream(s);
        drain_results();
    endtask

    task automatic test_backpressure();
        u8_t s [$];
        hold_left = 400;
        send_idle_pct = 0;
        build_stream(s, 1'b0, 6);
        send_stream(s);
        build_stream(s, 1'b1, 6);
        send_stream(s);
        drain_results();
    endtask

    task automatic test_random(input int n_bytes, input int sp, input int rp);
        u8_t s [$];
        int stop_at;
        send_idle_pct = sp;
        recv_idle_pct = rp;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(9) == 0) begin
                s.delete();
                repeat ($urandom_range(1, 6)) s.push_back(u8_t'($urandom));
            end else begin
                build_stream(s, 1'(($urandom_range(1))), $urandom_range(1, 5));
                corrupt_stream(s);
            end
            send_stream(s);
        end
        drain_results();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_byte     = '0;
        i_stream_last = 1'b0;
        i_out_ready   = 1'b0;
        send_idle_pct = 9;
        recv_idle_pct = 81;
        hold_left     = 0;
        bytes_sent    = 0;
        streams_sent  = 0;
        beats_checked = 0;
        mismatches    = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        clear_stream();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_headers();
        test_tokens();
        test_window();
        test_backpressure();
        test_random(25, 9, 81);
        test_random(25, 81, 9);
        test_random(25, 0, 0);

        $display("Covered %0d streams, %0d input bytes, %0d results checked.",
                 streams_sent, bytes_sent, beats_checked);
        $display("Status counts: ok %0d, truncated %0d, magic %0d, window %0d, limit %0d",
                 status_seen[ST_DONE], status_seen[ST_TRUNC], status_seen[ST_MAGIC],
                 status_seen[ST_OFF_WIN], status_seen[ST_LEN]);
        if (mismatches == 0 && decoded_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("%0t: timeout with %0d results outstanding", $time, decoded_q.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
